// ===== hdl/pklim_pkg.sv =====
// Shared types and constants for the per-key token bucket limiter.
// Holds the item structs, the table entry layout and the register codes.
// No dependencies.
package pklim_pkg;

    // Table geometry default
    localparam int ENTRIES_DEFAULT = 64;

    // Register map (index = paddr[3:2])
    localparam int          PADDR_W      = 4;
    localparam logic [1:0]  REG_CAPACITY = 2'd0;
    localparam logic [1:0]  REG_RATE     = 2'd1;
    localparam logic [1:0]  REG_TIMEOUT  = 2'd2;

    // Register reset values
    localparam logic [15:0] CAPACITY_RESET = 16'd10;
    localparam logic [31:0] RATE_RESET     = 32'd66;
    localparam logic [31:0] TIMEOUT_RESET  = 32'd60000;

    // Result status codes
    localparam logic [1:0]  ST_GRANTED    = 2'd0;
    localparam logic [1:0]  ST_LOW_TOKENS = 2'd1;
    localparam logic [1:0]  ST_TABLE_FULL = 2'd2;
    localparam logic [1:0]  ST_SWEEP_DONE = 2'd3;

    // Item modes
    localparam logic        MODE_REQUEST  = 1'b0;
    localparam logic        MODE_SWEEP    = 1'b1;

    // Saturation point of the removal counter
    localparam logic [6:0]  REMOVED_MAX   = 7'h7F;

    typedef struct packed {
        logic        mode;
        logic [31:0] client_ip;
        logic [15:0] consume_amount;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic        allowed;
        logic [1:0]  status;
        logic [6:0]  removed_count;
        logic [15:0] tokens_left;
    } t_out_item;

    // One bucket table word
    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [31:0] tokens;
        logic [31:0] last_ms;
    } t_entry;

    // Configuration register bank
    typedef struct packed {
        logic [15:0] capacity;
        logic [31:0] rate;
        logic [31:0] timeout;
    } t_cfg;

    // Outcome of one bucket update
    typedef struct packed {
        logic        allowed;
        logic [31:0] tokens;
    } t_bucket_res;

endpackage

// ===== hdl/per_key_token_bucket_limiter.sv =====
// Per-address token bucket limiter with a table scanned from one memory.
// One item at a time: a new item is taken only after the result of the last one
// is loaded into the result register. The table scan reads one memory word per cycle.
// After reset a clearing pass marks every entry free; no item
// is taken during it. Configuration writes are taken at all times.
module per_key_token_bucket_limiter #(
    parameter int ENTRIES = pklim_pkg::ENTRIES_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input beats
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pklim_pkg::t_in_item           i_in_data,
    // result beats
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pklim_pkg::t_out_item          o_out_data,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pklim_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int AW = $clog2(ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_DRAIN, S_DECIDE, S_CALC, S_REPLY
    } t_state;

    t_state                 r_state;
    logic [AW-1:0]          r_idx;
    logic                   r_rd_pend;
    logic [AW-1:0]          r_rd_idx;
    pklim_pkg::t_in_item    r_item;
    logic                   r_hit;
    logic [AW-1:0]          r_hit_idx;
    logic [31:0]            r_hit_tok;
    logic [31:0]            r_hit_last;
    logic                   r_free;
    logic [AW-1:0]          r_free_idx;
    logic [AW-1:0]          r_sel_idx;
    logic [6:0]             r_removed;
    pklim_pkg::t_out_item   r_res;
    logic                   r_out_valid;
    pklim_pkg::t_out_item   r_out;

    pklim_pkg::t_cfg        cfg;
    pklim_pkg::t_entry      rd_data;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    pklim_pkg::t_entry      mem_wdata;
    logic                   expired;
    logic [31:0]            cap_q;
    logic                   bk_start;
    logic [31:0]            bk_tokens;
    logic [31:0]            bk_elapsed;
    logic                   bk_done;
    pklim_pkg::t_bucket_res bk_res;

    pklim_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pklim_mem #(.ENTRIES(ENTRIES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    pklim_bucket u_bucket (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (bk_start),
        .i_tokens  (bk_tokens),
        .i_elapsed (bk_elapsed),
        .i_rate    (cfg.rate),
        .i_cap_q   (cap_q),
        .i_amount  (r_item.consume_amount),
        .o_done    (bk_done),
        .o_res     (bk_res)
    );

    assign cap_q   = {cfg.capacity, 16'd0};
    assign expired = (r_item.now_ms - rd_data.last_ms) >= cfg.timeout;

    // Start the bucket update on a hit or a fresh slot; a fresh bucket is full
    assign bk_start   = (r_state == S_DECIDE) && (r_item.mode == pklim_pkg::MODE_REQUEST)
                        && (r_hit || r_free);
    assign bk_tokens  = r_hit ? r_hit_tok : cap_q;
    assign bk_elapsed = r_hit ? (r_item.now_ms - r_hit_last) : 32'd0;

    // Memory write port: clear, sweep eviction, bucket write-back
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = rd_data;
        priority if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_idx;
            mem_wdata = '0;
        end else if (r_rd_pend && (r_item.mode == pklim_pkg::MODE_SWEEP)
                     && rd_data.valid && expired) begin
            mem_we        = 1'b1;
            mem_waddr     = r_rd_idx;
            mem_wdata     = rd_data;
            mem_wdata.valid = 1'b0;
        end else if ((r_state == S_CALC) && bk_done) begin
            mem_we            = 1'b1;
            mem_waddr         = r_sel_idx;
            mem_wdata.valid   = 1'b1;
            mem_wdata.address = r_item.client_ip;
            mem_wdata.tokens  = bk_res.tokens;
            mem_wdata.last_ms = r_item.now_ms;
        end else begin
            mem_we = 1'b0;
        end
    end

    // Sequencer, scan bookkeeping and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result beat once taken, unless a new one loads this cycle
            if (r_out_valid && !i_out_stall && (r_state != S_REPLY)) begin
                r_out_valid <= 1'b0;
            end

            r_rd_pend <= (r_state == S_SCAN);
            r_rd_idx  <= r_idx;

            // Examine the word read last cycle
            if (r_rd_pend) begin
                if (r_item.mode == pklim_pkg::MODE_SWEEP) begin
                    if (rd_data.valid && expired && (r_removed != pklim_pkg::REMOVED_MAX)) begin
                        r_removed <= r_removed + 7'd1;
                    end
                end else if (rd_data.valid) begin
                    if (!r_hit && (rd_data.address == r_item.client_ip)) begin
                        r_hit      <= 1'b1;
                        r_hit_idx  <= r_rd_idx;
                        r_hit_tok  <= rd_data.tokens;
                        r_hit_last <= rd_data.last_ms;
                    end
                end else if (!r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
            end

            unique case (r_state)
                S_CLEAR: begin
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item    <= i_in_data;
                        r_hit     <= 1'b0;
                        r_free    <= 1'b0;
                        r_removed <= '0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    priority if (r_item.mode == pklim_pkg::MODE_SWEEP) begin
                        r_res.allowed       <= 1'b0;
                        r_res.status        <= pklim_pkg::ST_SWEEP_DONE;
                        r_res.removed_count <= r_removed;
                        r_res.tokens_left   <= '0;
                        r_state             <= S_REPLY;
                    end else if (r_hit || r_free) begin
                        r_sel_idx <= r_hit ? r_hit_idx : r_free_idx;
                        r_state   <= S_CALC;
                    end else begin
                        r_res.allowed       <= 1'b0;
                        r_res.status        <= pklim_pkg::ST_TABLE_FULL;
                        r_res.removed_count <= '0;
                        r_res.tokens_left   <= '0;
                        r_state             <= S_REPLY;
                    end
                end
                S_CALC: begin
                    if (bk_done) begin
                        r_res.allowed       <= bk_res.allowed;
                        r_res.status        <= bk_res.allowed ? pklim_pkg::ST_GRANTED
                                                              : pklim_pkg::ST_LOW_TOKENS;
                        r_res.removed_count <= '0;
                        r_res.tokens_left   <= bk_res.tokens[31:16];
                        r_state             <= S_REPLY;
                    end
                end
                S_REPLY: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/pklim_mem.sv =====
// Bucket table memory: one write port, one read port, registered read data.
// Depends on pklim_pkg for the entry layout.
module pklim_mem #(
    parameter int ENTRIES = pklim_pkg::ENTRIES_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(ENTRIES)-1:0] i_waddr,
    input  pklim_pkg::t_entry          i_wdata,
    input  logic [$clog2(ENTRIES)-1:0] i_raddr,
    output pklim_pkg::t_entry          o_rdata
);

    pklim_pkg::t_entry r_ram [ENTRIES];
    pklim_pkg::t_entry r_rdata;

    // Write one word, read one word a cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_ram[i_waddr] <= i_wdata;
        end
        r_rdata <= r_ram[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pklim_regs.sv =====
// APB-style configuration registers: capacity, refill rate, idle timeout.
// Depends on pklim_pkg for the register map and reset values.
module pklim_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pklim_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output pklim_pkg::t_cfg               o_cfg
);

    pklim_pkg::t_cfg r_cfg;
    logic [1:0]      reg_idx;
    logic            wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // Take register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity <= pklim_pkg::CAPACITY_RESET;
            r_cfg.rate     <= pklim_pkg::RATE_RESET;
            r_cfg.timeout  <= pklim_pkg::TIMEOUT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                pklim_pkg::REG_CAPACITY: r_cfg.capacity <= pwdata[15:0];
                pklim_pkg::REG_RATE:     r_cfg.rate     <= pwdata;
                pklim_pkg::REG_TIMEOUT:  r_cfg.timeout  <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            pklim_pkg::REG_CAPACITY: prdata = {16'd0, r_cfg.capacity};
            pklim_pkg::REG_RATE:     prdata = r_cfg.rate;
            pklim_pkg::REG_TIMEOUT:  prdata = r_cfg.timeout;
            default:                 prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/pklim_bucket.sv =====
// Three-stage bucket update: refill product, saturating refill, consume.
// Depends on pklim_pkg for the result struct.
module pklim_bucket (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [31:0]            i_tokens,
    input  logic [31:0]            i_elapsed,
    input  logic [31:0]            i_rate,
    input  logic [31:0]            i_cap_q,
    input  logic [15:0]            i_amount,
    output logic                   o_done,
    output pklim_pkg::t_bucket_res o_res
);

    // Stage 1 registers
    logic        r1_valid;
    logic [63:0] r1_prod;
    logic        r1_nz;
    logic [31:0] r1_tok;
    logic [31:0] r1_cap;
    logic [31:0] r1_need;
    // Stage 2 registers
    logic        r2_valid;
    logic [31:0] r2_tok;
    logic [31:0] r2_need;
    // Stage 3 registers
    logic                   r3_valid;
    pklim_pkg::t_bucket_res r3_res;

    logic [64:0] sum;
    logic [31:0] n_tok2;

    // Saturating refill
    always_comb begin
        sum = {33'd0, r1_tok} + {1'b0, r1_prod};
        if (!r1_nz) begin
            n_tok2 = r1_tok;
        end else if (sum > {33'd0, r1_cap}) begin
            n_tok2 = r1_cap;
        end else begin
            n_tok2 = sum[31:0];
        end
    end

    // Advance the stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_start;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r1_prod <= {32'd0, i_elapsed} * {32'd0, i_rate};
        r1_nz   <= (i_elapsed != 32'd0);
        r1_tok  <= i_tokens;
        r1_cap  <= i_cap_q;
        r1_need <= {i_amount, 16'd0};

        r2_tok  <= n_tok2;
        r2_need <= r1_need;

        if (r2_tok >= r2_need) begin
            r3_res.allowed <= 1'b1;
            r3_res.tokens  <= r2_tok - r2_need;
        end else begin
            r3_res.allowed <= 1'b0;
            r3_res.tokens  <= r2_tok;
        end
    end

    assign o_done = r3_valid;
    assign o_res  = r3_res;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench for per_key_token_bucket_limiter: drives request and sweep beats,
// mirrors the bucket table to predict every verdict and compares each result beat.
// Depends on pklim_pkg and the limiter RTL.
module tb;
    import pklim_pkg::*;

    localparam int SLOTS            = ENTRIES_DEFAULT;
    localparam int RANDOM_PER_PHASE = 250;
    localparam int CYCLE_LIMIT      = 1000000;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out_data;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [31:0]         pwdata      = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Mirror of the limit registers and the bucket table
    logic [15:0]         lim_cap     = CAPACITY_RESET;
    logic [31:0]         lim_rate    = RATE_RESET;
    logic [31:0]         lim_timeout = TIMEOUT_RESET;
    logic                tbl_valid  [SLOTS];
    logic [31:0]         tbl_addr   [SLOTS];
    logic [31:0]         tbl_tokens [SLOTS];
    logic [31:0]         tbl_last   [SLOTS];

    t_out_item           pending_verdicts [$];
    t_out_item           want;
    int                  mismatch_count = 0;
    int                  verdicts_seen  = 0;
    int                  cycle_count    = 0;
    int                  idle_pct       = 27;

    per_key_token_bucket_limiter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i]  = 1'b0;
            tbl_addr[i]   = '0;
            tbl_tokens[i] = '0;
            tbl_last[i]   = '0;
        end
    end

    // Work out the verdict of one beat and advance the table mirror
    function automatic t_out_item predict_verdict(input t_in_item it);
        t_out_item   verdict;
        int          hit;
        int          free_slot;
        logic [31:0] cap_q;
        logic [31:0] elapsed;
        logic [31:0] need;
        logic [63:0] sum;
        logic [6:0]  freed;
        verdict = '0;
        cap_q = {lim_cap, 16'h0000};
        if (it.mode == MODE_SWEEP) begin
            freed = '0;
            for (int i = 0; i < SLOTS; i++) begin
                elapsed = it.now_ms - tbl_last[i];
                if (tbl_valid[i] && elapsed >= lim_timeout) begin
                    tbl_valid[i] = 1'b0;
                    if (freed != REMOVED_MAX)
                        freed = freed + 7'd1;
                end
            end
            verdict.status = ST_SWEEP_DONE;
            verdict.removed_count = freed;
            return verdict;
        end
        // Find the address, else the lowest free slot
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i]) begin
                if (hit < 0 && tbl_addr[i] == it.client_ip)
                    hit = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (hit < 0) begin
            if (free_slot < 0) begin
                verdict.status = ST_TABLE_FULL;
                return verdict;
            end
            hit = free_slot;
            tbl_valid[hit]  = 1'b1;
            tbl_addr[hit]   = it.client_ip;
            tbl_tokens[hit] = cap_q;
            tbl_last[hit]   = it.now_ms;
        end
        // Refill only on nonzero elapsed time, saturate at capacity
        elapsed = it.now_ms - tbl_last[hit];
        if (elapsed != 32'd0) begin
            sum = {32'h0, tbl_tokens[hit]} + {32'h0, elapsed} * {32'h0, lim_rate};
            tbl_tokens[hit] = (sum > {32'h0, cap_q}) ? cap_q : sum[31:0];
            tbl_last[hit] = it.now_ms;
        end
        need = {it.consume_amount, 16'h0000};
        if (tbl_tokens[hit] >= need) begin
            tbl_tokens[hit] = tbl_tokens[hit] - need;
            verdict.allowed = 1'b1;
            verdict.status = ST_GRANTED;
        end else begin
            verdict.status = ST_LOW_TOKENS;
        end
        verdict.tokens_left = tbl_tokens[hit][31:16];
        return verdict;
    endfunction

    function automatic t_in_item request_beat(input logic [31:0] ip, input logic [15:0] amount,
                                              input logic [31:0] now);
        t_in_item beat;
        beat.mode = MODE_REQUEST;
        beat.client_ip = ip;
        beat.consume_amount = amount;
        beat.now_ms = now;
        return beat;
    endfunction

    // Address and amount are don't-care on a sweep; fill them with noise
    function automatic t_in_item sweep_beat(input logic [31:0] now);
        t_in_item beat;
        beat.mode = MODE_SWEEP;
        beat.client_ip = $urandom;
        beat.consume_amount = 16'($urandom);
        beat.now_ms = now;
        return beat;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < 40)
            $display("ERROR: result beat %0d: %s", verdicts_seen, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] expected);
        if (got !== expected)
            flag_mismatch($sformatf("%s got 0x%0h, predicted 0x%0h", name, got, expected));
    endtask

    // Predict each accepted input beat
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            pending_verdicts.push_back(predict_verdict(i_in_data));
    end

    // Compare each accepted result beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            verdicts_seen++;
            if (pending_verdicts.size() == 0) begin
                flag_mismatch("result beat with no verdict pending");
            end else begin
                want = pending_verdicts.pop_front();
                check_field("allowed", 32'(o_out_data.allowed), 32'(want.allowed));
                check_field("status", 32'(o_out_data.status), 32'(want.status));
                check_field("removed_count", 32'(o_out_data.removed_count),
                            32'(want.removed_count));
                check_field("tokens_left", 32'(o_out_data.tokens_left),
                            32'(want.tokens_left));
            end
        end
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < idle_pct);
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Send one input beat after a random gap and hold it until taken
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    // Hold off input until every predicted verdict has come back;
    // first let the clock advance so the last accepted beat is already queued
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_CAPACITY: lim_cap = value[15:0];
            REG_RATE:     lim_rate = value;
            REG_TIMEOUT:  lim_timeout = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [15:0] cap, input logic [31:0] rate,
                              input logic [31:0] tmo);
        write_reg(REG_CAPACITY, {16'h0, cap});
        write_reg(REG_RATE, rate);
        write_reg(REG_TIMEOUT, tmo);
    endtask

    // Field extremes, clock wrap, zero elapsed time, clamping and sweep boundaries
    task automatic test_directed();
        send_item(request_beat(32'h0, 16'd0, 32'h0));
        send_item(request_beat(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_item(request_beat(32'h0, 16'd10, 32'h0));
        send_item(request_beat(32'h0, 16'd1, 32'h0));
        // time wraps past zero
        send_item(request_beat(32'hFFFF_FFFF, 16'd1, 32'd5));
        // clock seemingly running backward still counts as elapsed
        send_item(request_beat(32'h0, 16'd0, 32'hFFFF_FFF0));
        // one entry sits exactly at the timeout, the other just short of it
        send_item(sweep_beat(32'hFFFF_FFF0 + 32'd60000));
        send_item(request_beat(32'hA5A5_A5A5, 16'd3, 32'd100));

        // zero capacity: only an empty request passes
        wait_drained();
        write_reg(REG_CAPACITY, 32'd0);
        send_item(request_beat(32'h1234_5678, 16'd0, 32'd200));
        send_item(request_beat(32'h1234_5678, 16'd1, 32'd300));

        // top capacity and top rate: refill saturates
        wait_drained();
        write_reg(REG_CAPACITY, 32'd65535);
        write_reg(REG_RATE, 32'hFFFF_FFFF);
        send_item(request_beat(32'h0000_0001, 16'hFFFF, 32'd400));
        send_item(request_beat(32'h0000_0001, 16'd0, 32'd401));

        // lower capacity clamps only once time moves
        wait_drained();
        write_reg(REG_CAPACITY, 32'd3);
        write_reg(REG_RATE, 32'd0);
        send_item(request_beat(32'h0000_0001, 16'd0, 32'd401));
        send_item(request_beat(32'h0000_0001, 16'd0, 32'd402));
        send_item(request_beat(32'h0000_0001, 16'd4, 32'd402));

        // zero timeout frees every live entry
        wait_drained();
        write_reg(REG_TIMEOUT, 32'd0);
        send_item(sweep_beat(32'd402));
        send_item(sweep_beat(32'd402));

        // top timeout frees only an entry idle for the full wrap
        wait_drained();
        set_limits(16'd10, 32'd66, 32'hFFFF_FFFF);
        send_item(request_beat(32'h0BAD_F00D, 16'd2, 32'd1000));
        send_item(sweep_beat(32'd999));
        send_item(request_beat(32'h0BAD_F00D, 16'd2, 32'd1000));
        send_item(sweep_beat(32'd1000));
    endtask

    // Phases of random traffic over address pools of varying size
    task automatic test_random_traffic();
        logic [31:0] pool [$];
        logic [31:0] cursor;
        logic [31:0] ip;
        logic [15:0] cap;
        logic [15:0] amt;
        logic [31:0] rate;
        logic [31:0] tmo;
        int          pool_size;
        int          pick;
        cursor = $urandom;
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: begin
                    cap = 16'd10; rate = 32'd66; tmo = 32'd60000; pool_size = 12;
                end
                1: begin
                    cap = 16'd1; rate = 32'd0; tmo = 32'd0; pool_size = 40;
                end
                2: begin
                    cap = 16'hFFFF; rate = 32'hFFFF_FFFF; tmo = 32'hFFFF_FFFF;
                    pool_size = 90;
                end
                3: begin
                    cap = 16'($urandom_range(1, 64));
                    rate = $urandom_range(0, 1 << 20);
                    tmo = $urandom_range(0, 5000);
                    pool_size = 70;
                end
                4: begin
                    cap = 16'($urandom_range(1, 65535));
                    rate = $urandom;
                    tmo = $urandom;
                    pool_size = 8;
                end
                5: begin
                    cap = 16'd2; rate = 32'h0001_0000; tmo = 32'd1000; pool_size = 70;
                end
                default: begin
                    cap = 16'($urandom_range(1, 20));
                    rate = $urandom_range(0, 1 << 17);
                    tmo = $urandom_range(0, 20000);
                    pool_size = 30;
                end
            endcase
            wait_drained();
            set_limits(cap, rate, tmo);
            // no idling on either side through the saturating phase
            idle_pct = (phase == 2) ? 0 : 27;
            pool.delete();
            repeat (pool_size) pool.push_back($urandom);
            repeat (RANDOM_PER_PHASE) begin
                // advance time mostly in small steps, sometimes jump anywhere
                pick = $urandom_range(99);
                if (pick < 50)
                    cursor += $urandom_range(0, 2);
                else if (pick < 85)
                    cursor += $urandom_range(0, 3000);
                else if (pick < 95)
                    cursor += $urandom_range(0, 200000);
                else
                    cursor = $urandom;
                if ($urandom_range(99) < 5) begin
                    send_item(sweep_beat(cursor));
                end else begin
                    ip = ($urandom_range(9) == 0) ? $urandom : pool[$urandom_range(pool_size - 1)];
                    pick = $urandom_range(9);
                    if (pick < 7)
                        amt = 16'($urandom_range(0, lim_cap));
                    else if (pick < 9)
                        amt = 16'($urandom_range(0, 3));
                    else
                        amt = 16'($urandom);
                    send_item(request_beat(ip, amt, cursor));
                end
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_traffic();
        wait_drained();
        repeat (SLOTS + 16) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pklim_pkg.sv
hdl/pklim_mem.sv
hdl/pklim_regs.sv
hdl/pklim_bucket.sv
hdl/per_key_token_bucket_limiter.sv
test/tb.sv
